// ===== src/mawu_pkg.sv =====
package mawu_pkg;

  // Per-item classification made by the front end and carried out by the back end.
  typedef struct packed {
    logic sub;   // ring already full: the oldest sample leaves the sum
    logic full;  // window is full once this sample is counted
  } flags_t;

  localparam int unsigned FlagsBits = $bits(flags_t);

endpackage

// ===== src/moving_average_warmup_unit.sv =====
// Simple moving average over the last WINDOW converter samples, with warm-up: every
// transfer on the input channel yields exactly one transfer on the output channel,
// carrying the truncated mean of the samples held so far (fewer than WINDOW while the
// window fills, WINDOW afterwards) and a flag that is set from the WINDOW-th sample on.
// The front end tracks slot position and fill count and pushes each classified sample
// into a two-entry queue; the back end reads the outgoing ring entry, updates the
// running sum and divides it by the fill count in a restoring divider that retires one
// quotient bit per cycle. The back end works on one sample at a time; the queue and
// the output register let up to three further samples be taken while a result waits.
// The sample ring needs no clearing after reset.
module moving_average_warmup_unit #(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_average,
  output logic                   out_window_full
);

  // Widths of the slot position, the fill count and the running sum.
  localparam int unsigned IW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned EW = SAMPLE_BITS + IW + CW + mawu_pkg::FlagsBits;

  logic          push;
  logic [EW-1:0] push_data;
  logic          q_full;
  logic          pop;
  logic          q_not_empty;
  logic [EW-1:0] q_data;

  // The front end accepts a transfer whenever the queue has room.
  mawu_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IW          (IW),
    .CW          (CW),
    .EW          (EW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  mawu_queue #(
    .EW (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  // The back end holds the ring, the running sum, the divider and the output register.
  mawu_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IW          (IW),
    .CW          (CW),
    .SW          (SW),
    .EW          (EW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_data          (q_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_average     (out_average),
    .out_window_full (out_window_full)
  );

endmodule

// ===== src/mawu_front.sv =====
module mawu_front #(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned IW          = 5,
  parameter int unsigned CW          = 6,
  parameter int unsigned EW          = SAMPLE_BITS + IW + CW + mawu_pkg::FlagsBits
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   push,
  output logic [EW-1:0]          push_data,
  input  logic                   q_full
);

  localparam logic [IW-1:0] LastIdx = IW'(WINDOW - 1);
  localparam logic [CW-1:0] FullCnt = CW'(WINDOW);

  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    fill_after;
  mawu_pkg::flags_t flags;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // The front end owns slot position and fill count, so it can run ahead of the back end.
  always_comb begin
    flags.sub  = (fill_r == FullCnt);
    fill_after = flags.sub ? fill_r : fill_r + CW'(1);
    flags.full = (fill_after == FullCnt);
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    if (push) begin
      fill_nxt = fill_after;
      idx_nxt  = (idx_r == LastIdx) ? '0 : idx_r + IW'(1);
    end
  end

  assign push_data = {in_sample, idx_r, fill_after, flags};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      fill_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== src/mawu_queue.sv =====
module mawu_queue #(
  parameter int unsigned EW = 23
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [EW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [EW-1:0] pop_data
);

  // Two-entry queue between front and back end.
  logic [EW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/mawu_back.sv =====
module mawu_back #(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned IW          = 5,
  parameter int unsigned CW          = 6,
  parameter int unsigned SW          = 15,
  parameter int unsigned EW          = SAMPLE_BITS + IW + CW + mawu_pkg::FlagsBits
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_not_empty,
  input  logic [EW-1:0]          q_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_average,
  output logic                   out_window_full
);

  localparam int unsigned BW = (SW > 1) ? $clog2(SW) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] ring [WINDOW];
  logic [SAMPLE_BITS-1:0] old_r;

  logic [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          div_r, div_nxt;
  mawu_pkg::flags_t       flg_r, flg_nxt;

  logic [SW-1:0] sum_r, sum_nxt;
  logic [SW-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   trial;
  logic          qbit;

  logic                   ov_r, ov_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic                   wf_r, wf_nxt;
  logic                   out_free;
  logic                   ring_we;

  assign pop             = (state_r == S_IDLE) && q_not_empty;
  assign ring_we         = (state_r == S_SUM);
  assign out_free        = !ov_r || out_ready;
  assign out_valid       = ov_r;
  assign out_average     = avg_r;
  assign out_window_full = wf_r;

  assign trial = {rem_r, dvd_r[SW-1]};
  assign qbit  = (trial >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    smp_nxt   = smp_r;
    idx_nxt   = idx_r;
    div_nxt   = div_r;
    flg_nxt   = flg_r;
    sum_nxt   = sum_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    avg_nxt   = avg_r;
    wf_nxt    = wf_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          {smp_nxt, idx_nxt, div_nxt, flg_nxt} = q_data;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt   = sum_r - (flg_r.sub ? SW'(old_r) : '0) + SW'(smp_r);
        dvd_nxt   = sum_nxt;
        rem_nxt   = '0;
        cnt_nxt   = BW'(SW - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = qbit ? CW'(trial - {1'b0, div_r}) : trial[CW-1:0];
        dvd_nxt = {dvd_r[SW-2:0], qbit};
        cnt_nxt = cnt_r - BW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          avg_nxt   = dvd_r[SAMPLE_BITS-1:0];
          wf_nxt    = flg_r.full;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sample ring: the outgoing entry is read when the item is taken and
  // overwritten in the S_SUM state that follows.
  always_ff @(posedge clk) begin
    if (pop) begin
      old_r <= ring[q_data[EW-SAMPLE_BITS-1 -: IW]];
    end
    if (ring_we) begin
      ring[idx_r] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
    idx_r <= idx_nxt;
    div_r <= div_nxt;
    flg_r <= flg_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    avg_r <= avg_nxt;
    wf_r  <= wf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Window     = 32;
  localparam int unsigned SampleBits = 10;
  localparam int unsigned SampleMax  = (1 << SampleBits) - 1;
  localparam int unsigned ItemCount  = 650;
  localparam int unsigned IdlePct    = 37;
  localparam int unsigned MaxCycles  = 200000;
  localparam int unsigned DrainWait  = 60;

  // A queue entry with this value is not a sample. It tells the sender to hold off
  // until every predicted average has been seen on the output channel.
  localparam int HoldMarker = -1;

  // Items counted from here up to SteadyEnd are sent and received with no idling.
  localparam int unsigned SteadyStart = 300;
  localparam int unsigned SteadyEnd   = 450;

  typedef struct packed {
    logic [SampleBits-1:0] average;
    logic                  window_full;
  } avg_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [SampleBits-1:0] in_sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [SampleBits-1:0] out_average;
  logic                  out_window_full;

  moving_average_warmup_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_window_full(out_window_full)
  );

  // Samples waiting to be sent, and the averages predicted for samples already taken.
  int          pending_samples[$];
  avg_result_t expected_averages[$];

  // Our own copy of the averaging state: the sample history, its sum, the next slot
  // to overwrite and how many samples are held so far.
  logic [SampleBits-1:0] history[Window];
  int unsigned           history_sum;
  int unsigned           next_slot;
  int unsigned           held_count;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned taken_count;
  logic        sample_taken;
  logic        steady;
  avg_result_t got_average;
  avg_result_t want_average;

  always #1 clk = ~clk;

  // Advance the averaging state by one sample and return the average it produces.
  // During warm-up the sum grows and the divisor is the number of samples held; once
  // the history is full the oldest sample leaves the sum and the divisor stays Window.
  task automatic advance_average(input logic [SampleBits-1:0] sample,
                                 output avg_result_t result);
    if (held_count < Window) begin
      held_count++;
    end else begin
      history_sum -= history[next_slot];
    end
    history[next_slot] = sample;
    history_sum += sample;
    next_slot = (next_slot == Window - 1) ? 0 : next_slot + 1;
    result.average     = SampleBits'(history_sum / held_count);
    result.window_full = (held_count == Window);
  endtask

  // Append a run of samples of one kind to the pending queue. Runs of all-maximum or
  // all-zero samples are long enough to push the window through a full turn, so that the
  // write position wraps and the oldest sample really leaves the sum.
  task automatic add_run(input int unsigned kind, input int unsigned len);
    int unsigned level;
    int          value;
    level = $urandom_range(0, SampleMax);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        0: value = $urandom_range(0, SampleMax);
        1: value = SampleMax;
        2: value = 0;
        3: value = (i % 2 == 0) ? SampleMax : 0;
        4: value = $urandom_range(0, 7);
        default: begin
          value = int'(level) + $urandom_range(0, 6) - 3;
          if (value < 0) value = 0;
          if (value > int'(SampleMax)) value = SampleMax;
        end
      endcase
      pending_samples.push_back(value);
    end
  endtask

  // Input side. The driver changes its outputs at the falling edge only. A new sample
  // is presented when the channel is empty or the previous transfer has just happened,
  // so valid never drops while a sample is still waiting to be taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sample_taken) begin
      if (pending_samples.size() != 0 && pending_samples[0] == HoldMarker &&
          expected_averages.size() == 0) begin
        void'(pending_samples.pop_front());
      end
      if (pending_samples.size() == 0 || pending_samples[0] == HoldMarker ||
          (!steady && $urandom_range(0, 99) < IdlePct)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid  <= 1'b1;
        in_sample <= SampleBits'(pending_samples.pop_front());
      end
    end
  end

  // Output side. The receiver stalls at random except during the steady stretch.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Monitor and predictor, both at the rising edge. An output transfer is checked
  // before the input transfer of the same edge is predicted; a sample can never
  // produce its average at the very edge on which it is taken, so the order is safe.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("%0t: timeout after %0d cycles, %0d averages still expected",
               $realtime, cycle_count, expected_averages.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_average.average     = out_average;
        got_average.window_full = out_window_full;
        if (expected_averages.size() == 0) begin
          $display("%0t: unexpected output transfer, average %0d window_full %0b",
                   $realtime, out_average, out_window_full);
          error_count++;
        end else begin
          want_average = expected_averages.pop_front();
          if (got_average.average !== want_average.average) begin
            $display("%0t: average mismatch, expected %0d actual %0d",
                     $realtime, want_average.average, got_average.average);
            error_count++;
          end
          if (got_average.window_full !== want_average.window_full) begin
            $display("%0t: window_full mismatch, expected %0b actual %0b",
                     $realtime, want_average.window_full, got_average.window_full);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_average(in_sample, want_average);
        expected_averages.push_back(want_average);
        taken_count++;
      end
      sample_taken <= in_valid && in_ready;
      steady       <= (taken_count >= SteadyStart) && (taken_count < SteadyEnd);
    end else begin
      sample_taken <= 1'b0;
      steady       <= 1'b0;
    end
  end

  initial begin
    int unsigned queued;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    out_ready    = 1'b0;
    sample_taken = 1'b0;
    steady       = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    taken_count  = 0;
    history_sum  = 0;
    next_slot    = 0;
    held_count   = 0;
    foreach (history[i]) history[i] = '0;

    // Directed part: the sample extremes right at the start of warm-up, where the
    // divisor is tiny, then values that toggle every sample bit, then a hold-off so
    // the block drains completely before the random part begins.
    pending_samples = '{SampleMax, 0, SampleMax, 1, 512, 511, 0, SampleMax,
                        341, 682, 1, SampleMax - 1, 2, 1021, 256, 768};
    pending_samples.push_back(HoldMarker);
    queued = 16;

    // Random part: runs of varied character until the item budget is used up. A
    // second hold-off follows the run that reaches a third of the item budget.
    while (queued < ItemCount) begin
      int unsigned kind;
      int unsigned len;
      kind = $urandom_range(0, 5);
      len  = (kind == 1 || kind == 2) ? $urandom_range(Window + 1, Window + 8)
                                      : $urandom_range(1, 40);
      if (queued + len > ItemCount) len = ItemCount - queued;
      add_run(kind, len);
      if (queued < ItemCount / 3 && queued + len >= ItemCount / 3) begin
        pending_samples.push_back(HoldMarker);
      end
      queued += len;
    end

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Wait until every sample has been taken and every predicted average has come
    // out, then give the block some further time to show any stray output transfer.
    while (pending_samples.size() != 0 || in_valid || expected_averages.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainWait) @(negedge clk);

    if (expected_averages.size() != 0) begin
      $display("%0t: %0d averages never arrived", $realtime, expected_averages.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mawu_pkg.sv
src/mawu_front.sv
src/mawu_queue.sv
src/mawu_back.sv
src/moving_average_warmup_unit.sv
tb/tb_top.sv
